// ----- rtl/efd_pkg.sv -----
// efd_pkg: shared types and constants of the deduplicating event queue
// beat payload structs, status codes, controller/datapath command and status
// no dependencies
`timescale 1ns / 1ps

package efd_pkg;

  localparam int DEFAULT_DEPTH = 8;
  localparam int CODE_W        = 8;
  localparam int STATUS_W      = 3;

  // command field values
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // status codes of a result beat
  localparam logic [STATUS_W-1:0] ST_PUSHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_START  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_END    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd6;

  typedef struct packed {
    logic              command;
    logic [CODE_W-1:0] event_code;
  } efd_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   event_out;
  } efd_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // take the input beat, read head slot, start scan
    logic scan_rd;  // read slot at scan pointer and step it
    logic set_dup;  // duplicate found
    logic commit;   // update queue state and load the output register
  } efd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;    // latched command is a pop
    logic scan_end;  // scan pointer reached the write pointer
    logic match;     // last slot read equals the latched code
    logic out_free;  // output register can take a result this cycle
  } efd_sts_t;

endpackage

// ----- rtl/efd_ctrl.sv -----
// efd_ctrl: sequencer for the event queue (accept, scan, compare, commit)
// depends on efd_pkg for the command and status structs
`timescale 1ns / 1ps

module efd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  efd_pkg::efd_sts_t sts,
  output efd_pkg::efd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // pops skip the scan
        if (sts.is_pop || sts.scan_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.set_dup = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/efd_datapath.sv -----
// efd_datapath: slot memory, pointers, burst flag, compare and output register
// depends on efd_pkg; driven by efd_ctrl commands
`timescale 1ns / 1ps

module efd_datapath #(
  parameter int DEPTH = efd_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  efd_pkg::efd_in_t  in_data,
  input  efd_pkg::efd_cmd_t cmd,
  output efd_pkg::efd_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output efd_pkg::efd_out_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == LAST) n = '0;
    else           n = p + 1'b1;
    return n;
  endfunction

  logic [efd_pkg::CODE_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]           scan_ptr_r;
  logic                       idle_r, idle_nxt;
  logic                       dup_r;
  logic                       cmd_r;
  logic [efd_pkg::CODE_W-1:0] code_r;
  logic [efd_pkg::CODE_W-1:0] rdata_r;
  logic                       out_valid_r;
  efd_pkg::efd_out_t          out_data_r, out_data_nxt;
  logic                       mem_we;
  logic [PTR_W-1:0]           rd_addr;

  assign rd_addr = cmd.load ? rd_ptr_r : scan_ptr_r;

  assign sts.is_pop   = (cmd_r == efd_pkg::CMD_POP);
  assign sts.scan_end = (scan_ptr_r == wr_ptr_r);
  assign sts.match    = (rdata_r == code_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // result and next queue state, used only on commit
  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    idle_nxt     = idle_r;
    mem_we       = 1'b0;
    out_data_nxt = '0;
    if (cmd_r == efd_pkg::CMD_PUSH) begin
      if (dup_r) begin
        out_data_nxt.status = efd_pkg::ST_DUP;
      end else if (wrap_next(wr_ptr_r) == rd_ptr_r) begin
        out_data_nxt.status = efd_pkg::ST_FULL;
      end else begin
        mem_we              = cmd.commit;
        wr_ptr_nxt          = wrap_next(wr_ptr_r);
        out_data_nxt.status = efd_pkg::ST_PUSHED;
      end
    end else if (rd_ptr_r == wr_ptr_r) begin
      if (!idle_r) begin
        idle_nxt            = 1'b1;
        out_data_nxt.status = efd_pkg::ST_END;
      end else begin
        out_data_nxt.status = efd_pkg::ST_NONE;
      end
    end else if (idle_r) begin
      idle_nxt            = 1'b0;
      out_data_nxt.status = efd_pkg::ST_START;
    end else begin
      rd_ptr_nxt             = wrap_next(rd_ptr_r);
      out_data_nxt.status    = efd_pkg::ST_POPPED;
      out_data_nxt.event_out = rdata_r;
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= code_r;
    end
    if (cmd.load || cmd.scan_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // beat payload and scan state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_data.command;
      code_r     <= in_data.event_code;
      scan_ptr_r <= rd_ptr_r;
    end else if (cmd.scan_rd) begin
      scan_ptr_r <= wrap_next(scan_ptr_r);
    end
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      idle_r      <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        dup_r <= 1'b0;
      end else if (cmd.set_dup) begin
        dup_r <= 1'b1;
      end
      if (cmd.commit) begin
        rd_ptr_r    <= rd_ptr_nxt;
        wr_ptr_r    <= wr_ptr_nxt;
        idle_r      <= idle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/event_fifo_with_dedup.sv -----
// event_fifo_with_dedup: top level of the deduplicating event queue
// instantiates efd_ctrl and efd_datapath; types from efd_pkg
`timescale 1ns / 1ps
//
// usage
// - input channel in_valid/in_ready/in_data carries one command per beat:
//   a push of event_code or a pop request
// - every input beat yields exactly one result beat on out_valid/out_ready/
//   out_data: status plus the popped code (zero unless status is popped)
// - a push is checked against every queued code by a scan through the slot
//   memory, one slot at a time (registered read, then compare); a
//   duplicate is dropped, a push into a queue holding DEPTH-1 codes is
//   dropped and flagged full
// - pops frame bursts: an empty queue gives one end marker, then results
//   of status none; after an end marker, the first pop with codes queued
//   gives a start marker
// - a push scans the queued codes before its commit (scan stops on a hit),
//   a pop skips the scan; one item is in work at a time
// - reset (rst_n low, synchronous) empties the queue, clears the burst
//   flag and drops any pending result; slot contents are not cleared
// - a stalled receiver holds the result in the output register; the next
//   input beat is still taken and worked on, and waits for the register
//   only at its commit step
//
module event_fifo_with_dedup #(
  parameter int DEPTH = efd_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  efd_pkg::efd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output efd_pkg::efd_out_t out_data
);

  // command and status between sequencer and datapath
  efd_pkg::efd_cmd_t cmd;
  efd_pkg::efd_sts_t sts;

  efd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  efd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/efd_checker.sv -----
// efd_checker: port-level assertions for event_fifo_with_dedup
// depends on efd_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module efd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input efd_pkg::efd_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // code only travels with a pop
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != efd_pkg::ST_POPPED |-> out_data.event_out == '0)
    else $error("event code on a non-pop result");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind event_fifo_with_dedup efd_checker u_efd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
